@@ src/rws_pkg.sv @@
// Shared constants for the roulette wheel selector.
package rws_pkg;

    // Default table geometry
    localparam int POPULATION_DEF   = 64;
    localparam int FITNESS_BITS_DEF = 16;

    // Fixed port field widths
    localparam int IDX_PORT_W   = 6;
    localparam int FIT_PORT_W   = 16;
    localparam int FRAC_W       = 16;
    localparam int TOT_PORT_W   = 22;
    localparam int FRAC_CNT_W   = $clog2(FRAC_W);

    // Transaction op codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SELECT = 1'b1;

endpackage

@@ src/rws_fit_ram.sv @@
// Fitness table storage: one write port, one read port with registered data.
module rws_fit_ram #(
    parameter int DEPTH = rws_pkg::POPULATION_DEF,
    parameter int WIDTH = rws_pkg::FITNESS_BITS_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/roulette_wheel_selector.sv @@
// Roulette wheel selector top level: sequencer, shared adder datapath, output register.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_op, i_member_index, i_fitness_value,
//          |           |                         | i_random_fraction
//  out     | output    | o_out_valid / i_out_stall| o_chosen_index, o_fitness_total
//
// Sequencing: a write transaction steps through accept, read old entry, then
// update table and total. A select transaction is accepted, then 16 shift-add
// steps form the slice, then the scan reads one table entry per cycle through
// the single RAM read port and stops at the first hit; the result then goes
// to the output register.
// Reset: a clearing pass writes zero to every entry, with o_in_stall high
// throughout.
// Stalls: a new transaction is taken while a result still waits in the output
// register; a finished select waits in its last state until that register frees.
module roulette_wheel_selector #(
    parameter int POPULATION   = rws_pkg::POPULATION_DEF,
    parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [rws_pkg::IDX_PORT_W-1:0]  i_member_index,
    input  logic [rws_pkg::FIT_PORT_W-1:0]  i_fitness_value,
    input  logic [rws_pkg::FRAC_W-1:0]      i_random_fraction,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [rws_pkg::IDX_PORT_W-1:0]  o_chosen_index,
    output logic [rws_pkg::TOT_PORT_W-1:0]  o_fitness_total
);

    localparam int IDX_W = $clog2(POPULATION);
    // sum of POPULATION entries of FITNESS_BITS always fits here
    localparam int TOT_W = FITNESS_BITS + $clog2(POPULATION);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POPULATION - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WR_READ,
        S_WR_UPD,
        S_MUL,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                        r_state, n_state;
    logic [IDX_W-1:0]              r_idx, n_idx;        // clear / write / scan index
    logic [FITNESS_BITS-1:0]       r_wfit, n_wfit;      // fitness for pending write
    logic [TOT_W-1:0]              r_total, n_total;    // running table sum
    logic [rws_pkg::FRAC_W-1:0]    r_frac, n_frac;      // multiplier bits, LSB first
    logic [rws_pkg::FRAC_CNT_W-1:0] r_mul_cnt, n_mul_cnt;
    logic [TOT_W-1:0]              r_acc, n_acc;        // product high part, then prefix sum
    logic [TOT_W-1:0]              r_slice, n_slice;
    logic [IDX_W-1:0]              r_chosen, n_chosen;
    logic                          r_out_valid, n_out_valid;
    logic [rws_pkg::IDX_PORT_W-1:0] r_out_idx, n_out_idx;
    logic [rws_pkg::TOT_PORT_W-1:0] r_out_tot, n_out_tot;

    // RAM hookup
    logic                    ram_wr_en;
    logic [IDX_W-1:0]        ram_wr_addr;
    logic [FITNESS_BITS-1:0] ram_wr_data;
    logic [IDX_W-1:0]        ram_rd_addr;
    logic [FITNESS_BITS-1:0] ram_rd_data;

    // shared adder
    logic [TOT_W:0]          add_a, add_b, add_sum;
    logic                    in_fire, out_fire;

    rws_fit_ram #(
        .DEPTH (POPULATION),
        .WIDTH (FITNESS_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign out_fire   = r_out_valid && !i_out_stall;

    // one adder serves the multiply steps and the scan accumulation
    always_comb begin
        add_a = {1'b0, r_acc};
        add_b = '0;
        if (r_state == S_MUL) begin
            add_b = r_frac[0] ? {1'b0, r_total} : '0;
        end else begin
            add_b = (TOT_W + 1)'(ram_rd_data);
        end
        add_sum = add_a + add_b;
    end

    // read address: during scan look one entry ahead of the data in hand
    always_comb begin
        case (r_state)
            S_WR_READ: ram_rd_addr = r_idx;
            S_SCAN:    ram_rd_addr = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            default:   ram_rd_addr = '0;
        endcase
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx;
        ram_wr_data = r_wfit;
        case (r_state)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = '0;
            end
            S_WR_UPD: ram_wr_en = 1'b1;
            default:  ram_wr_en = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_wfit      = r_wfit;
        n_total     = r_total;
        n_frac      = r_frac;
        n_mul_cnt   = r_mul_cnt;
        n_acc       = r_acc;
        n_slice     = r_slice;
        n_chosen    = r_chosen;
        n_out_valid = out_fire ? 1'b0 : r_out_valid;
        n_out_idx   = r_out_idx;
        n_out_tot   = r_out_tot;

        case (r_state)
            S_CLEAR: begin
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    if (i_op == rws_pkg::OP_SELECT) begin
                        n_frac    = i_random_fraction;
                        n_mul_cnt = '0;
                        n_acc     = '0;
                        n_state   = S_MUL;
                    end else if (32'(i_member_index) < POPULATION) begin
                        // out-of-range writes are dropped
                        n_idx   = IDX_W'(i_member_index);
                        n_wfit  = FITNESS_BITS'(i_fitness_value);
                        n_state = S_WR_READ;
                    end
                end
            end
            S_WR_READ: n_state = S_WR_UPD;
            S_WR_UPD: begin
                n_total = r_total - TOT_W'(ram_rd_data) + TOT_W'(r_wfit);
                n_state = S_IDLE;
            end
            S_MUL: begin
                // right-shift multiply keeps only the high part: floor(frac*total/2^16)
                n_acc     = add_sum[TOT_W:1];
                n_frac    = r_frac >> 1;
                n_mul_cnt = r_mul_cnt + 1'b1;
                if (r_mul_cnt == rws_pkg::FRAC_CNT_W'(rws_pkg::FRAC_W - 1)) begin
                    n_slice = add_sum[TOT_W:1];
                    n_acc   = '0;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_acc = add_sum[TOT_W-1:0];
                if (add_sum > {1'b0, r_slice}) begin
                    n_chosen = r_idx;
                    n_state  = S_DONE;
                end else if (r_idx == LAST_IDX) begin
                    n_chosen = '0;       // nothing exceeds the slice (zero total)
                    n_state  = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || out_fire) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = rws_pkg::IDX_PORT_W'(r_chosen);
                    n_out_tot   = rws_pkg::TOT_PORT_W'(r_total);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
        r_wfit    <= n_wfit;
        r_frac    <= n_frac;
        r_mul_cnt <= n_mul_cnt;
        r_acc     <= n_acc;
        r_slice   <= n_slice;
        r_chosen  <= n_chosen;
        r_out_idx <= n_out_idx;
        r_out_tot <= n_out_tot;
    end

    assign o_out_valid     = r_out_valid;
    assign o_chosen_index  = r_out_idx;
    assign o_fitness_total = r_out_tot;

endmodule

@@ tb/tb_roulette_wheel_selector.sv @@
// Self-checking testbench for the roulette wheel selector: directed and random traffic.
`timescale 1ns / 1ps

module tb_roulette_wheel_selector;

    localparam int IDX_PORT_W = rws_pkg::IDX_PORT_W;
    localparam int FIT_PORT_W = rws_pkg::FIT_PORT_W;
    localparam int TOT_PORT_W = rws_pkg::TOT_PORT_W;
    localparam int FRAC_W     = rws_pkg::FRAC_W;
    localparam logic OP_WRITE  = rws_pkg::OP_WRITE;
    localparam logic OP_SELECT = rws_pkg::OP_SELECT;

    localparam int POP       = rws_pkg::POPULATION_DEF;
    localparam int FIT_MAX   = (1 << FIT_PORT_W) - 1;
    localparam int RAND_ITEMS = 1430;
    localparam int BLOCK_LEN  = 150;

    // Random-phase table shapes
    typedef enum int {
        SHAPE_DENSE,   // random indices, mixed values
        SHAPE_SPARSE,  // sweep writes zero below the top entries -> long scans
        SHAPE_FULL     // sweep writes every entry at full scale -> largest total
    } t_table_shape;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the fitness table and running total, predicts
    // the chosen member for each select transaction.
    // ------------------------------------------------------------------
    class t_selection_scoreboard;
        bit [FIT_PORT_W-1:0]  fit_table [0:POP-1];
        bit [TOT_PORT_W-1:0]  total;
        bit [IDX_PORT_W-1:0]  chosen_q [$];
        bit [TOT_PORT_W-1:0]  total_q [$];
        int errors;
        int n_writes;
        int n_selects;
        int n_checked;
        int n_deep;
        int max_total;

        function new();
            foreach (fit_table[i]) fit_table[i] = '0;
            total     = '0;
            errors    = 0;
            n_writes  = 0;
            n_selects = 0;
            n_checked = 0;
            n_deep    = 0;
            max_total = 0;
        endfunction

        // First member whose cumulative fitness exceeds the slice, else 0.
        function bit [IDX_PORT_W-1:0] spin_wheel(bit [FRAC_W-1:0] frac);
            bit [FRAC_W+TOT_PORT_W-1:0] slice;
            bit [TOT_PORT_W:0]          acc;
            bit [IDX_PORT_W-1:0]        pick;
            bit                         found;
            slice = ((FRAC_W+TOT_PORT_W)'(frac) * (FRAC_W+TOT_PORT_W)'(total)) >> FRAC_W;
            acc   = '0;
            pick  = '0;
            found = 1'b0;
            for (int i = 0; i < POP; i++) begin
                acc = acc + fit_table[i];
                if (!found && acc > slice) begin
                    pick  = i[IDX_PORT_W-1:0];
                    found = 1'b1;
                end
            end
            return pick;
        endfunction

        function void note_input(bit op, bit [IDX_PORT_W-1:0] idx,
                                 bit [FIT_PORT_W-1:0] fit, bit [FRAC_W-1:0] frac);
            bit [IDX_PORT_W-1:0] pick;
            if (op == OP_WRITE) begin
                n_writes++;
                // With 64 entries every 6-bit index is in range.
                if (int'(idx) < POP) begin
                    total          = total - fit_table[idx] + fit;
                    fit_table[idx] = fit;
                end
                if (int'(total) > max_total) max_total = int'(total);
            end else begin
                n_selects++;
                pick = spin_wheel(frac);
                if (pick >= 48) n_deep++;
                chosen_q = {chosen_q, pick};
                total_q  = {total_q, total};
            end
        endfunction

        function void check_result(bit [IDX_PORT_W-1:0] chosen, bit [TOT_PORT_W-1:0] tot);
            bit [IDX_PORT_W-1:0] exp_idx;
            bit [TOT_PORT_W-1:0] exp_tot;
            if (chosen_q.size() == 0) begin
                $error("result with nothing pending: chosen_index=%0d fitness_total=%0d",
                       chosen, tot);
                errors++;
                return;
            end
            exp_idx = chosen_q.pop_front();
            exp_tot = total_q.pop_front();
            n_checked++;
            if (chosen !== exp_idx) begin
                $error("chosen_index: expected %0d, got %0d", exp_idx, chosen);
                errors++;
            end
            if (tot !== exp_tot) begin
                $error("fitness_total: expected %0d, got %0d", exp_tot, tot);
                errors++;
            end
        endfunction

        function int pending();
            return chosen_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value.
    // ------------------------------------------------------------------
    logic                   i_clk             = 1'b0;
    logic                   i_rst_n           = 1'b0;
    logic                   i_in_valid        = 1'b0;
    logic                   o_in_stall;
    logic                   i_op              = OP_WRITE;
    logic [IDX_PORT_W-1:0]  i_member_index    = '0;
    logic [FIT_PORT_W-1:0]  i_fitness_value   = '0;
    logic [FRAC_W-1:0]      i_random_fraction = '0;
    logic                   o_out_valid;
    logic                   i_out_stall       = 1'b0;
    logic [IDX_PORT_W-1:0]  o_chosen_index;
    logic [TOT_PORT_W-1:0]  o_fitness_total;

    t_selection_scoreboard sb = new();

    bit no_gaps = 1'b0;   // set for stretches of back-to-back transactions

    roulette_wheel_selector u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_member_index    (i_member_index),
        .i_fitness_value   (i_fitness_value),
        .i_random_fraction (i_random_fraction),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_chosen_index    (o_chosen_index),
        .o_fitness_total   (o_fitness_total)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Idle length between transactions: mostly none or short, now and then long.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Drive one transaction and hold it until o_in_stall is seen low. Valid is only dropped
    // when an idle gap follows, so back-to-back items keep it high.
    task automatic send_txn(input logic op, input logic [IDX_PORT_W-1:0] idx,
                            input logic [FIT_PORT_W-1:0] fit,
                            input logic [FRAC_W-1:0] frac);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_op              <= op;
        i_member_index    <= idx;
        i_fitness_value   <= fit;
        i_random_fraction <= frac;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(op, idx, fit, frac);
    endtask

    // Write with random fraction bits; select with random (ignored) index and fitness.
    task automatic write_fit(input int idx, input int fit);
        send_txn(OP_WRITE, idx[IDX_PORT_W-1:0], fit[FIT_PORT_W-1:0],
                 FRAC_W'($urandom_range(0, FIT_MAX)));
    endtask

    task automatic select_one(input int frac);
        send_txn(OP_SELECT, IDX_PORT_W'($urandom_range(0, POP-1)),
                 FIT_PORT_W'($urandom_range(0, FIT_MAX)), frac[FRAC_W-1:0]);
    endtask

    // Output side: random stall bursts, occasional long holds, quiet stretches.
    initial begin : out_stall_gen
        int  len;
        bit  quiet;
        forever begin
            quiet = ($urandom_range(0, 7) == 0);
            len   = quiet ? $urandom_range(50, 300) : $urandom_range(1, 20);
            repeat (len) begin
                @(posedge i_clk);
                i_out_stall <= quiet ? 1'b0 : ($urandom_range(0, 3) == 0);
            end
            if (!quiet && $urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(4, 40)) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
        end
    end

    // Result monitor: a transaction completes when valid is high and stall is low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_chosen_index, o_fitness_total);
        end
    end

    // Watchdog: a run that hangs ends here with errors reported.
    initial begin : watchdog
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        t_table_shape shape;
        int           seq_idx;
        int           idx;
        int           fit;
        int           r;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- Directed part ---
        // Empty wheel: slice is zero, nothing exceeds it, member 0 comes back.
        select_one(FIT_MAX);
        select_one(0);
        // Single entry at the far end: full-length scan, both fraction extremes.
        write_fit(POP-1, FIT_MAX);
        select_one(0);
        select_one(FIT_MAX);
        // Lowest entry catches a zero slice.
        write_fit(0, 1);
        select_one(0);
        select_one(FIT_MAX);
        // Overwrite: total must drop the old value before adding the new.
        write_fit(POP-1, 16'h1234);
        write_fit(0, 0);
        select_one(16'h8000);
        write_fit(31, 16'hAAAA);
        write_fit(32, 16'h5555);
        select_one(16'h7FFF);
        select_one(16'hFFFE);
        // Zero-valued write over a zero entry leaves the total alone.
        write_fit(5, 0);
        select_one(1);
        // Clear back to empty, check zero total again.
        write_fit(POP-1, 0);
        write_fit(31, 0);
        write_fit(32, 0);
        select_one(16'h4000);

        // --- Random part, in blocks that shape the table differently ---
        seq_idx = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % BLOCK_LEN == 0) begin
                shape   = t_table_shape'((n / BLOCK_LEN) % 3);
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 1) == 0) begin
                r = $urandom_range(0, 99);
                // Structured blocks sweep indices in order; some writes stay noise.
                if (shape == SHAPE_DENSE || r < 15) begin
                    idx = $urandom_range(0, POP-1);
                    r   = $urandom_range(0, 99);
                    if (r < 25)      fit = 0;
                    else if (r < 35) fit = FIT_MAX;
                    else if (r < 55) fit = $urandom_range(1, 15);
                    else             fit = $urandom_range(0, FIT_MAX);
                end else begin
                    idx     = seq_idx;
                    seq_idx = (seq_idx + 1) % POP;
                    if (shape == SHAPE_FULL) fit = FIT_MAX;
                    else                     fit = (idx >= POP-8) ? $urandom_range(0, FIT_MAX) : 0;
                end
                write_fit(idx, fit);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5)       select_one(0);
                else if (r < 10) select_one(FIT_MAX);
                else             select_one($urandom_range(0, FIT_MAX));
            end
        end
        i_in_valid <= 1'b0;

        // Drain: wait for outstanding results, then keep watching for stray results.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end

        $display("Covered %0d fitness writes and %0d selections, %0d results compared.",
                 sb.n_writes, sb.n_selects, sb.n_checked);
        $display("Peak wheel total %0d; %0d selections landed in the top quarter.",
                 sb.max_total, sb.n_deep);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
